@@ rtl/btxn_pkg.sv @@
// shared types and constants for the binary trie xor nearest unit
`timescale 1ns / 1ps
`default_nettype none

package btxn_pkg;

    localparam int KEY_W    = 32;
    localparam int STATUS_W = 2;

    // item modes
    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_QUERY  = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WALK,
        S_ALLOC,
        S_QLEAF,
        S_RESULT
    } state_t;

endpackage

`default_nettype wire

@@ rtl/btxn_ifs.sv @@
// valid/ready channel interfaces for request and response beats
`timescale 1ns / 1ps
`default_nettype none

interface btxn_req_if;
    logic                       valid;
    logic                       ready;
    logic                       mode;
    logic [btxn_pkg::KEY_W-1:0] key;

    modport source (output valid, output mode, output key, input ready);
    modport sink   (input valid, input mode, input key, output ready);
endinterface

interface btxn_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [btxn_pkg::KEY_W-1:0]    found_key;
    logic [btxn_pkg::STATUS_W-1:0] status;

    modport source (output valid, output found_key, output status, input ready);
    modport sink   (input valid, input found_key, input status, output ready);
endinterface

`default_nettype wire

@@ rtl/binary_trie_xor_nearest_unit.sv @@
// binary xor trie: insert keys and find the stored key nearest by xor
`timescale 1ns / 1ps
`default_nettype none

//  channel | role | beat payload       | handshake
//  --------+------+--------------------+------------------
//  req     | sink | mode, key          | valid & ready
//  rsp     | src  | found_key, status  | valid & ready
//
//  one trie level per cycle, paced by the registered read of the link ram
//  full walk: the response register loads from S_RESULT after the last level
//  (queries pass S_QLEAF first), next accept once back in idle; empty query and full
//  insert stop at the level where they fail; req.ready is high only in idle
//  a finished result waits in the sequencer until the response register is free
//  reset clears the root links in flops and sets the node count to one; no ram clearing

module binary_trie_xor_nearest_unit #(
    parameter int KEY_BITS  = 32,
    parameter int MAX_NODES = 4096
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    btxn_req_if.sink    req,
    btxn_rsp_if.source  rsp
);

    localparam int KW      = btxn_pkg::KEY_W;
    localparam int SW      = btxn_pkg::STATUS_W;
    localparam int NODE_W  = $clog2(MAX_NODES);
    localparam int CNT_W   = $clog2(MAX_NODES + 1);
    localparam int LINK_W  = NODE_W + 1;
    localparam int ENTRY_W = 2 * LINK_W;
    localparam int LVL_W   = $clog2(KEY_BITS + 1);
    localparam int SUM_W   = $clog2(MAX_NODES + KEY_BITS + 1) + 1;

    // keys wider than the port read as zero above bit 31
    localparam logic [63:0] MASK64 = (KEY_BITS >= 64) ? {64{1'b1}}
                                   : ((64'd1 << KEY_BITS) - 64'd1);
    localparam logic [KW-1:0] KEY_MASK = MASK64[KW-1:0];

    // sequencer and datapath registers
    btxn_pkg::state_t    state_reg, state_next;
    logic [ENTRY_W-1:0]  root_reg, root_next;
    logic [NODE_W-1:0]   cur_reg, cur_next;
    logic [LVL_W-1:0]    level_reg, level_next;
    logic [KEY_BITS-1:0] path_reg, path_next;
    logic [KW-1:0]       key_reg, key_next;
    logic                mode_reg, mode_next;
    logic [CNT_W-1:0]    used_reg, used_next;
    logic [KW-1:0]       found_reg, found_next;
    logic [SW-1:0]       status_reg, status_next;
    logic                out_valid_reg, out_valid_next;
    logic [KW-1:0]       out_found_reg, out_found_next;
    logic [SW-1:0]       out_status_reg, out_status_next;

    // ram ports
    logic                link_wr_en;
    logic [ENTRY_W-1:0]  link_wr_data;
    logic [ENTRY_W-1:0]  link_rd_data;
    logic                leaf_wr_en;
    logic [NODE_W-1:0]   leaf_wr_addr;
    logic [KW-1:0]       leaf_rd_data;
    logic                rd_en;

    // current node decode
    logic [ENTRY_W-1:0]  word;
    logic                bit_cur;
    logic                v0, v1;
    logic [NODE_W-1:0]   idx0, idx1;
    logic                want_valid, alt_valid, take_valid;
    logic [NODE_W-1:0]   want_idx, alt_idx, take_idx, next_idx;
    logic                last_level;
    logic [SUM_W-1:0]    need_sum;
    logic                pool_full;
    logic [NODE_W-1:0]   new_idx;
    logic [LINK_W-1:0]   new_link;
    logic [ENTRY_W-1:0]  merged_entry, alloc_entry;
    logic                out_free;
    logic [63:0]         key64;

    // the root lives in flops, every other node in the link ram
    assign word       = (cur_reg == '0) ? root_reg : link_rd_data;
    assign bit_cur    = path_reg[KEY_BITS-1];
    assign v0         = word[NODE_W];
    assign idx0       = word[NODE_W-1:0];
    assign v1         = word[ENTRY_W-1];
    assign idx1       = word[ENTRY_W-2:LINK_W];
    assign want_valid = bit_cur ? v1 : v0;
    assign want_idx   = bit_cur ? idx1 : idx0;
    assign alt_valid  = bit_cur ? v0 : v1;
    assign alt_idx    = bit_cur ? idx0 : idx1;
    // query falls back to the other branch when the wanted one is missing
    assign take_valid = want_valid | alt_valid;
    assign take_idx   = want_valid ? want_idx : alt_idx;
    assign next_idx   = (mode_reg == btxn_pkg::MODE_QUERY) ? take_idx : want_idx;
    assign last_level = (level_reg == LVL_W'(KEY_BITS - 1));

    // nodes this insert still needs: one per remaining level
    assign need_sum  = SUM_W'(used_reg) + (SUM_W'(KEY_BITS) - SUM_W'(level_reg));
    assign pool_full = (need_sum > SUM_W'(MAX_NODES));

    assign new_idx  = used_reg[NODE_W-1:0];
    assign new_link = {1'b1, new_idx};

    always_comb
    begin
        merged_entry = word;
        alloc_entry  = '0;
        if (bit_cur)
        begin
            merged_entry[ENTRY_W-1:LINK_W] = new_link;
            alloc_entry[ENTRY_W-1:LINK_W]  = new_link;
        end
        else
        begin
            merged_entry[LINK_W-1:0] = new_link;
            alloc_entry[LINK_W-1:0]  = new_link;
        end
    end

    assign out_free = !out_valid_reg || rsp.ready;
    assign key64    = {32'd0, req.key};

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            btxn_pkg::S_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = btxn_pkg::S_WALK;
                end
            end
            btxn_pkg::S_WALK:
            begin
                if (mode_reg == btxn_pkg::MODE_QUERY)
                begin
                    if (!take_valid)
                    begin
                        state_next = btxn_pkg::S_RESULT;
                    end
                    else if (last_level)
                    begin
                        state_next = btxn_pkg::S_QLEAF;
                    end
                end
                else if (want_valid)
                begin
                    if (last_level)
                    begin
                        state_next = btxn_pkg::S_RESULT;
                    end
                end
                else if (pool_full || last_level)
                begin
                    state_next = btxn_pkg::S_RESULT;
                end
                else
                begin
                    state_next = btxn_pkg::S_ALLOC;
                end
            end
            btxn_pkg::S_ALLOC:
            begin
                if (last_level)
                begin
                    state_next = btxn_pkg::S_RESULT;
                end
            end
            btxn_pkg::S_QLEAF:
            begin
                state_next = btxn_pkg::S_RESULT;
            end
            btxn_pkg::S_RESULT:
            begin
                if (out_free)
                begin
                    state_next = btxn_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = btxn_pkg::S_IDLE;
            end
        endcase
    end

    // datapath and ram controls
    always_comb
    begin
        root_next       = root_reg;
        cur_next        = cur_reg;
        level_next      = level_reg;
        path_next       = path_reg;
        key_next        = key_reg;
        mode_next       = mode_reg;
        used_next       = used_reg;
        found_next      = found_reg;
        status_next     = status_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_found_next  = out_found_reg;
        out_status_next = out_status_reg;
        link_wr_en      = 1'b0;
        link_wr_data    = alloc_entry;
        leaf_wr_en      = 1'b0;
        leaf_wr_addr    = new_idx;
        rd_en           = 1'b0;

        case (state_reg)
            btxn_pkg::S_IDLE:
            begin
                if (req.valid)
                begin
                    mode_next   = req.mode;
                    key_next    = req.key & KEY_MASK;
                    path_next   = key64[KEY_BITS-1:0];
                    cur_next    = '0;
                    level_next  = '0;
                    found_next  = '0;
                    status_next = btxn_pkg::STATUS_OK;
                end
            end
            btxn_pkg::S_WALK:
            begin
                // fetch the next node while this level is decided
                rd_en      = 1'b1;
                cur_next   = next_idx;
                level_next = level_reg + LVL_W'(1);
                path_next  = path_reg << 1;
                if (mode_reg == btxn_pkg::MODE_QUERY)
                begin
                    if (!take_valid)
                    begin
                        status_next = btxn_pkg::STATUS_EMPTY;
                    end
                end
                else if (want_valid)
                begin
                    // existing path, rewrite the leaf at the bottom
                    if (last_level)
                    begin
                        leaf_wr_en   = 1'b1;
                        leaf_wr_addr = want_idx;
                    end
                end
                else if (pool_full)
                begin
                    status_next = btxn_pkg::STATUS_FULL;
                end
                else
                begin
                    // hang a fresh node under the current one
                    link_wr_data = merged_entry;
                    if (cur_reg == '0)
                    begin
                        root_next = merged_entry;
                    end
                    else
                    begin
                        link_wr_en = 1'b1;
                    end
                    cur_next  = new_idx;
                    used_next = used_reg + CNT_W'(1);
                    if (last_level)
                    begin
                        leaf_wr_en = 1'b1;
                    end
                end
            end
            btxn_pkg::S_ALLOC:
            begin
                // chain of new nodes, each with one link to the next
                link_wr_en   = 1'b1;
                link_wr_data = alloc_entry;
                cur_next     = new_idx;
                used_next    = used_reg + CNT_W'(1);
                level_next   = level_reg + LVL_W'(1);
                path_next    = path_reg << 1;
                if (last_level)
                begin
                    leaf_wr_en = 1'b1;
                end
            end
            btxn_pkg::S_QLEAF:
            begin
                found_next = leaf_rd_data;
            end
            btxn_pkg::S_RESULT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_found_next  = found_reg;
                    out_status_next = status_reg;
                end
            end
            default:
            begin
                out_valid_next = out_valid_reg;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= btxn_pkg::S_IDLE;
            root_reg      <= '0;
            used_reg      <= CNT_W'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            root_reg      <= root_next;
            used_reg      <= used_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        cur_reg        <= cur_next;
        level_reg      <= level_next;
        path_reg       <= path_next;
        key_reg        <= key_next;
        mode_reg       <= mode_next;
        found_reg      <= found_next;
        status_reg     <= status_next;
        out_found_reg  <= out_found_next;
        out_status_reg <= out_status_next;
    end

    // child links of every non-root node
    btxn_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_NODES)
    ) u_link_ram (
        .clk     (clk),
        .wr_en   (link_wr_en),
        .wr_addr (cur_reg),
        .wr_data (link_wr_data),
        .rd_en   (rd_en),
        .rd_addr (next_idx),
        .rd_data (link_rd_data)
    );

    // key recorded at each leaf
    btxn_ram #(
        .WIDTH (KW),
        .DEPTH (MAX_NODES)
    ) u_leaf_ram (
        .clk     (clk),
        .wr_en   (leaf_wr_en),
        .wr_addr (leaf_wr_addr),
        .wr_data (key_reg),
        .rd_en   (rd_en),
        .rd_addr (next_idx),
        .rd_data (leaf_rd_data)
    );

    assign req.ready     = (state_reg == btxn_pkg::S_IDLE);
    assign rsp.valid     = out_valid_reg;
    assign rsp.found_key = out_found_reg;
    assign rsp.status    = out_status_reg;

endmodule

`default_nettype wire

@@ rtl/btxn_ram.sv @@
// generic single write port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module btxn_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output      logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire
